// File: rtl/downmix_linear_resampler_core_macros.svh
// Assertion macros shared by the downmix linear resampler RTL.
`ifndef DOWNMIX_LINEAR_RESAMPLER_CORE_MACROS_SVH
`define DOWNMIX_LINEAR_RESAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DLR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlr assertion failed");
// Next-cycle implication, disabled during reset.
`define DLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlr assertion failed");
`else
`define DLR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DLR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/dlr_pkg.sv
// Shared types, constants and tables of the downmix linear resampler.
package dlr_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 16;

   localparam int InChannels = 8;
   localparam int ChanLimit  = (MAX_CHANNELS < InChannels) ? MAX_CHANNELS : InChannels;

   localparam int ReqDataBits = ((InChannels * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RspDataBits = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam int CountBits = 4;
   localparam int StepBits  = 20;
   localparam int PosBits   = 21;
   localparam int FracBits  = 16;

   // Q5.16 position and Q4.16 step constants
   localparam logic [PosBits-1:0]  OneQ16  = 21'd65536;
   localparam logic [PosBits-1:0]  TwoQ16  = 21'd131072;
   localparam logic [StepBits-1:0] StepMin = 20'd32768;
   localparam logic [StepBits-1:0] StepMax = 20'd786432;

   // register indexes of the configuration port
   localparam int CsrIdxBits = 1;
   localparam logic [CsrIdxBits-1:0] CsrChannelCount = 1'b0;
   localparam logic [CsrIdxBits-1:0] CsrPhaseStep    = 1'b1;

   // downmix: sum of up to eight channels, divided through a reciprocal
   localparam int SumBits   = SAMPLE_BITS + 3;
   localparam int RecipK    = SumBits + 3;
   localparam int RecipBits = RecipK + 1;
   localparam int ProdBits  = SumBits + RecipBits;

   localparam longint unsigned RecipOne = 64'd1 << RecipK;
   localparam logic [RecipBits-1:0] Recip1 = RecipBits'(RecipOne);
   localparam logic [RecipBits-1:0] Recip2 = RecipBits'((RecipOne + 1) / 2);
   localparam logic [RecipBits-1:0] Recip3 = RecipBits'((RecipOne + 2) / 3);
   localparam logic [RecipBits-1:0] Recip4 = RecipBits'((RecipOne + 3) / 4);
   localparam logic [RecipBits-1:0] Recip5 = RecipBits'((RecipOne + 4) / 5);
   localparam logic [RecipBits-1:0] Recip6 = RecipBits'((RecipOne + 5) / 6);
   localparam logic [RecipBits-1:0] Recip7 = RecipBits'((RecipOne + 6) / 7);
   localparam logic [RecipBits-1:0] Recip8 = RecipBits'((RecipOne + 7) / 8);

   localparam int QueueDepth   = 4;
   localparam int QueueIdxBits = 2;
   localparam int QueueCntBits = 3;

   typedef struct packed {
      logic [CountBits-1:0] channel_count;
      logic [StepBits-1:0]  phase_step;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mono;
      logic                          last;
   } mono_item_type;

   // ceil(2^RecipK / n), exact floor quotient for every sum magnitude
   function automatic logic [RecipBits-1:0] recip_q(input logic [CountBits-1:0] n);
      logic [RecipBits-1:0] r;
      unique case (n)
         4'd2:    r = Recip2;
         4'd3:    r = Recip3;
         4'd4:    r = Recip4;
         4'd5:    r = Recip5;
         4'd6:    r = Recip6;
         4'd7:    r = Recip7;
         4'd8:    r = Recip8;
         default: r = Recip1;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/dlr_front.sv
// Front end: accepts frames, downmixes them to mono and pushes them to the queue.
module dlr_front import dlr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   push_valid,
   output mono_item_type          push_item,
   input  logic                   queue_full
);

   localparam int Sb = SAMPLE_BITS;

   logic                 s0_valid_ff, s0_valid_in;
   logic signed [Sb-1:0] s0_chan_ff [InChannels];
   logic signed [Sb-1:0] s0_chan_in [InChannels];
   logic [CountBits-1:0] s0_count_ff, s0_count_in;
   logic                 s0_last_ff;

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [SumBits-1:0] s1_sum_ff, s1_sum_in;
   logic [CountBits-1:0]      s1_count_ff;
   logic                      s1_last_ff;

   logic                s2_valid_ff, s2_valid_in;
   logic [ProdBits-1:0] s2_prod_ff, s2_prod_in;
   logic                s2_neg_ff, s2_neg_in;
   logic                s2_last_ff;

   logic                 advance;
   logic [SumBits-1:0]   mag;
   logic [SumBits-1:0]   mag_round;
   logic [Sb-1:0]        quot;

   // the whole pipeline holds while its last stage cannot push
   assign advance    = !s2_valid_ff || !queue_full;
   assign req_tready = advance;

   always_comb begin
      if (cfg.channel_count == '0) begin
         s0_count_in = CountBits'(1);
      end else if (cfg.channel_count > CountBits'(ChanLimit)) begin
         s0_count_in = CountBits'(ChanLimit);
      end else begin
         s0_count_in = cfg.channel_count;
      end
      for (int c = 0; c < InChannels; c++) begin
         if (CountBits'(c) < s0_count_in) begin
            s0_chan_in[c] = $signed(req_tdata[c*Sb +: Sb]);
         end else begin
            s0_chan_in[c] = '0;
         end
      end
   end

   always_comb begin
      s1_sum_in = '0;
      for (int c = 0; c < InChannels; c++) begin
         s1_sum_in = s1_sum_in + SumBits'(s0_chan_ff[c]);
      end
   end

   always_comb begin
      s2_neg_in  = s1_sum_ff[SumBits-1];
      mag        = s2_neg_in ? SumBits'(-s1_sum_ff) : SumBits'(s1_sum_ff);
      mag_round  = mag + SumBits'(s1_count_ff >> 1);
      s2_prod_in = ProdBits'(mag_round) * ProdBits'(recip_q(s1_count_ff));
   end

   assign quot = s2_prod_ff[RecipK +: Sb];

   assign s0_valid_in = advance ? req_tvalid  : s0_valid_ff;
   assign s1_valid_in = advance ? s0_valid_ff : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   assign push_valid     = s2_valid_ff && !queue_full;
   assign push_item.mono = s2_neg_ff ? $signed(-quot) : $signed(quot);
   assign push_item.last = s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_chan_ff  <= s0_chan_in;
         s0_count_ff <= s0_count_in;
         s0_last_ff  <= req_tlast;
         s1_sum_ff   <= s1_sum_in;
         s1_count_ff <= s0_count_ff;
         s1_last_ff  <= s0_last_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_neg_ff   <= s2_neg_in;
         s2_last_ff  <= s1_last_ff;
      end
   end

endmodule

// File: rtl/dlr_queue.sv
// Short queue of mono samples between the front and back ends.
module dlr_queue import dlr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  mono_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output mono_item_type head_item
);

`include "downmix_linear_resampler_core_macros.svh"

   mono_item_type            entry_ff [QueueDepth];
   logic [QueueIdxBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueueIdxBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]  cnt_ff, cnt_in;
   logic                     do_push;
   logic                     do_pop;

   assign full      = (cnt_ff == QueueCntBits'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `DLR_ASSERT_IMPL(a_push_not_full, clock, reset, push_valid, !full)
   `DLR_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, not_empty)
   `DLR_ASSERT_NEXT(a_fill_tracks, clock, reset, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

// File: rtl/dlr_back.sv
// Back end: interpolates between mono samples and drives the output register.
module dlr_back import dlr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   item_valid,
   input  mono_item_type          item,
   output logic                   item_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

`include "downmix_linear_resampler_core_macros.svh"

   localparam int Sb      = SAMPLE_BITS;
   localparam int AccBits = Sb + 18;

   localparam logic [1:0] BackIdle  = 2'd0;
   localparam logic [1:0] BackCheck = 2'd1;
   localparam logic [1:0] BackMul   = 2'd2;
   localparam logic [1:0] BackEmit  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic signed [Sb-1:0] prior_ff, prior_in;
   logic [PosBits-1:0]   next_pos_ff, next_pos_in;
   logic                 started_ff, started_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [PosBits-1:0]   pos_ff, pos_in;
   logic signed [Sb-1:0] a_ff, a_in;
   logic signed [Sb-1:0] b_ff, b_in;
   logic signed [Sb-1:0] cur_ff, cur_in;
   logic                 last_ff, last_in;
   logic                 seg2_ff, seg2_in;
   logic [AccBits-1:0]   prod_ff, prod_in;
   logic [Sb-1:0]        rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [StepBits-1:0]    step;
   logic [PosBits-1:0]     npos;
   logic signed [Sb:0]     diff;
   logic signed [FracBits:0] frac;
   logic signed [AccBits-1:0] mul;
   logic [AccBits-1:0]     acc;
   logic                   done;
   logic                   emit_go;

   always_comb begin
      if (cfg.phase_step < StepMin) begin
         step = StepMin;
      end else if (cfg.phase_step > StepMax) begin
         step = StepMax;
      end else begin
         step = cfg.phase_step;
      end
   end

   assign npos = pos_ff + PosBits'(step);
   assign diff = $signed({b_ff[Sb-1], b_ff}) - $signed({a_ff[Sb-1], a_ff});
   assign frac = $signed({1'b0, pos_ff[FracBits-1:0]});
   assign mul  = diff * frac;
   // a * 65536 + product, rounded half up
   assign acc  = {{2{a_ff[Sb-1]}}, a_ff, 16'h0000} + prod_ff + AccBits'(32768);
   // flag the final output of a last frame
   assign done = seg2_ff ? (npos >= OneQ16) : (last_ff && (npos >= TwoQ16));
   assign emit_go = (state_ff == BackEmit) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      prior_in     = prior_ff;
      next_pos_in  = next_pos_ff;
      started_in   = started_ff;
      pos_in       = pos_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      seg2_in      = seg2_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      item_pop     = 1'b0;
      unique case (state_ff)
         BackIdle: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item.mono;
               last_in  = item.last;
               if (started_ff) begin
                  a_in     = prior_ff;
                  b_in     = item.mono;
                  pos_in   = next_pos_ff;
                  seg2_in  = 1'b0;
                  state_in = BackCheck;
               end else if (item.last) begin
                  a_in     = item.mono;
                  b_in     = item.mono;
                  pos_in   = '0;
                  seg2_in  = 1'b1;
                  state_in = BackCheck;
               end else begin
                  prior_in    = item.mono;
                  next_pos_in = '0;
                  started_in  = 1'b1;
               end
            end
         end
         BackCheck: begin
            if (pos_ff < OneQ16) begin
               state_in = BackMul;
            end else if (!seg2_ff) begin
               if (last_ff) begin
                  // hold the final sample for the rest of the packet
                  pos_in  = pos_ff - OneQ16;
                  a_in    = cur_ff;
                  b_in    = cur_ff;
                  seg2_in = 1'b1;
               end else begin
                  prior_in    = cur_ff;
                  next_pos_in = pos_ff - OneQ16;
                  started_in  = 1'b1;
                  state_in    = BackIdle;
               end
            end else begin
               prior_in    = '0;
               next_pos_in = '0;
               started_in  = 1'b0;
               state_in    = BackIdle;
            end
         end
         BackMul: begin
            prod_in  = AccBits'(mul);
            state_in = BackEmit;
         end
         BackEmit: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc[Sb+15:16];
               rsp_last_in  = done;
               pos_in       = npos;
               state_in     = BackCheck;
            end
         end
         default: state_in = BackIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BackIdle;
         prior_ff     <= '0;
         next_pos_ff  <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prior_ff     <= prior_in;
         next_pos_ff  <= next_pos_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      seg2_ff     <= seg2_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataBits'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   `DLR_ASSERT_IMPL(a_idle_clean, clock, reset, !started_ff, {next_pos_ff, prior_ff} == '0)
   `DLR_ASSERT_IMPL(a_phase_bounded, clock, reset, started_ff, next_pos_ff < PosBits'(StepMax))
   `DLR_ASSERT_NEXT(a_emit_next, clock, reset, emit_go, rsp_valid_ff && (state_ff == BackCheck))

endmodule

// File: rtl/downmix_linear_resampler_core.sv
// Top level of the downmix linear resampler: configuration registers and wiring.
// Usage:
//   req_* carries one frame per request: eight Q1.15 channel samples in tdata
//   and the end-of-packet mark in tlast. csr_* writes channel_count (index 0)
//   and phase_step (index 1); csr_ready is always high, writes belong to idle
//   periods. rsp_* delivers mono samples, tlast on the packet's final output
//   sample.
//   The front end is a three-stage downmix pipeline that takes one request per
//   cycle into a four-entry queue unless its last stage waits on a full queue.
//   The back end drains the queue: it picks up a frame while idle, then steps
//   through phase check, multiply, and round and load for each output, and a
//   final phase check closes each interval. It takes the next frame only once
//   the current one is done, and round and load waits while the output
//   register holds a sample not yet taken.
//   A stalled receiver holds the output register; the back end keeps working
//   until its next output, then the queue fills and req_tready drops.
//   Synchronous reset clears the pipeline, queue, packet phase and the
//   registers to one channel and a step of 65536.
module downmix_linear_resampler_core import dlr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // chan0 [15:0], chan1 [31:16], ... chan7 [127:112]
   input  logic [ReqDataBits-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // mono_sample [15:0]
   output logic [RspDataBits-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [StepBits-1:0]    csr_data
);

   cfg_type       cfg_ff, cfg_in;
   logic          push_valid;
   mono_item_type push_item;
   logic          queue_full;
   logic          item_valid;
   logic          item_pop;
   mono_item_type head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrChannelCount: cfg_in.channel_count = csr_data[CountBits-1:0];
            CsrPhaseStep:    cfg_in.phase_step    = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= CountBits'(1);
         cfg_ff.phase_step    <= StepBits'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   dlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (item_pop),
      .not_empty  (item_valid),
      .head_item  (head_item)
   );

   dlr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (head_item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
